FILE: sv/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                               32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

  // datapath commands
  typedef struct packed {
    logic put_byte;     // store in_data_byte at the fill position
    logic put_pad;      // store pad byte and clear rest of block
    logic zero_block;   // clear whole block
    logic put_len;      // write bit length into words 14 and 15
    logic load;         // load window and working registers
    logic round;        // run one round
    logic finish;       // fold working registers into chaining value
    logic reset_msg;    // back to initial value, count zero
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;      // byte position within the block
    logic       last_rnd; // round 63 in progress
  } stat_t;

  function automatic word_t rotl(word_t x, logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t p0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

FILE: sv/sm3_datapath.sv
// ----------------------------------------------------------------------------
// SM3 datapath
// Block buffer, byte count, message expansion window and round logic.
// ----------------------------------------------------------------------------
module sm3_datapath import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] byte_in,
  input  logic [2:0] rd_idx,
  output word_t      cv_word,
  output stat_t      stat
);

  word_t       blk_r [16];
  word_t       win_r [16];
  word_t       reg_r [8];
  word_t       cv_r  [8];
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;

  word_t wj, wj4, wnew, ff, gg, tc, a12, ss1, ss2, tt1, tt2, x;
  logic [63:0] bits;

  assign stat.pos      = cnt_r[5:0];
  assign stat.last_rnd = (rnd_r == 6'd63);
  assign cv_word       = cv_r[rd_idx];
  assign bits          = {cnt_r, 3'b000};

  always_comb begin
    // window is a shift line: win_r[0] is W[j], win_r[4] is W[j+4]
    x    = win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15);
    wnew = p1(x) ^ rotl(win_r[3], 5'd7) ^ win_r[10];
    wj   = win_r[0];
    wj4  = win_r[4];
    if (rnd_r < 6'd16) begin
      tc = T_LOW;
      ff = reg_r[0] ^ reg_r[1] ^ reg_r[2];
      gg = reg_r[4] ^ reg_r[5] ^ reg_r[6];
    end else begin
      tc = T_HIGH;
      ff = (reg_r[0] & reg_r[1]) | (reg_r[0] & reg_r[2]) | (reg_r[1] & reg_r[2]);
      gg = (reg_r[4] & reg_r[5]) | (~reg_r[4] & reg_r[6]);
    end
    a12 = rotl(reg_r[0], 5'd12);
    ss1 = rotl(a12 + reg_r[4] + rotl(tc, rnd_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + reg_r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + reg_r[7] + ss1 + wj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
    end else begin
      if (cmd.put_byte) begin
        blk_r[cnt_r[5:2]][(5'd3 - {3'b000, cnt_r[1:0]})*8 +: 8] <= byte_in;
        cnt_r <= cnt_r + 61'd1;
      end
      if (cmd.put_pad) begin
        for (int b = 0; b < 64; b++) begin
          if (6'(b) == cnt_r[5:0]) blk_r[b/4][(3-b%4)*8 +: 8] <= PAD_BYTE;
          else if (6'(b) > cnt_r[5:0]) blk_r[b/4][(3-b%4)*8 +: 8] <= 8'h00;
        end
      end
      if (cmd.zero_block) for (int i = 0; i < 16; i++) blk_r[i] <= '0;
      if (cmd.put_len) begin
        blk_r[14] <= bits[63:32];
        blk_r[15] <= bits[31:0];
      end
      if (cmd.load) begin
        for (int i = 0; i < 16; i++) win_r[i] <= blk_r[i];
        for (int i = 0; i < 8; i++) reg_r[i] <= cv_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
        win_r[15] <= wnew;
        reg_r[3] <= reg_r[2];
        reg_r[2] <= rotl(reg_r[1], 5'd9);
        reg_r[1] <= reg_r[0];
        reg_r[0] <= tt1;
        reg_r[7] <= reg_r[6];
        reg_r[6] <= rotl(reg_r[5], 5'd19);
        reg_r[5] <= reg_r[4];
        reg_r[4] <= p0(tt2);
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.finish) for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ reg_r[i];
      if (cmd.reset_msg) begin
        cnt_r <= '0;
        for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
      end
    end
  end

endmodule

FILE: sv/sm3_ctrl.sv
// ----------------------------------------------------------------------------
// SM3 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_has_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_word_index,
  output logic       out_last_word,
  output cmd_t       cmd,
  input  stat_t      stat
);

  localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_RUN = 3'd2, S_FOLD = 3'd3,
                         S_PAD  = 3'd4, S_ZERO = 3'd5, S_LEN = 3'd6, S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       eom_r, eom_nxt;     // padding pending after the current block
  logic       ovf_r, ovf_nxt;     // padded block overflowed, length-only block follows
  logic       final_r, final_nxt; // current compression is the last one
  logic [2:0] idx_r, idx_nxt;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    eom_nxt   = eom_r;
    ovf_nxt   = ovf_r;
    final_nxt = final_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.put_byte = in_has_byte;
          if (in_has_byte && stat.pos == 6'd63) begin
            state_nxt = S_LOAD;
            eom_nxt   = in_end_of_message;
            final_nxt = 1'b0;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.round = 1'b1;
        if (stat.last_rnd) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        // fold once round 63 has landed in the working registers
        cmd.finish = 1'b1;
        if (final_r) begin
          state_nxt = S_OUT;
          idx_nxt   = '0;
        end else if (eom_r) begin
          eom_nxt   = 1'b0;
          state_nxt = S_PAD;
        end else if (ovf_r) begin
          ovf_nxt   = 1'b0;
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        cmd.put_pad = 1'b1;
        if (stat.pos >= 6'd56) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_ZERO: begin
        cmd.zero_block = 1'b1;
        state_nxt      = S_LEN;
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        final_nxt   = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.reset_msg = 1'b1;
            state_nxt     = S_IDLE;
            final_nxt     = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      eom_r   <= 1'b0;
      ovf_r   <= 1'b0;
      final_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      eom_r   <= eom_nxt;
      ovf_r   <= ovf_nxt;
      final_r <= final_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: sv/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Hashes a byte stream with SM3 and emits the 256-bit digest as 8 words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per accepted item: an
//   optional message byte (in_has_byte) and an end mark (in_end_of_message).
//   Bytes are taken one per cycle while a block fills. The 64th byte of a
//   block starts the compression: a load step, 64 rounds at one per
//   cycle and a fold step; in_ready is low throughout.
//   On the end mark the engine pads, adds the bit length and compresses
//   once or twice (twice when fewer than 9 bytes remain in the block),
//   then presents eight digest words on out_* with out_word_index 0..7
//   and out_last_word on word 7.
//   The round loop sets the rate: no byte of the next block is taken
//   while a block is compressed.
//   A stalled receiver (out_ready low) holds the current word; no new input
//   is taken until the last word has gone. Afterwards the chaining value
//   returns to the SM3 initial value and the byte count to zero.
//   Reset (rst_n low, synchronous) loads the initial value and idles.
// ----------------------------------------------------------------------------
module sm3_hash_engine import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  cmd_t  cmd;
  stat_t stat;

  sm3_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_has_byte, .in_end_of_message,
    .out_valid, .out_ready, .out_word_index, .out_last_word,
    .cmd, .stat
  );

  sm3_datapath u_dp (
    .clk, .rst_n, .cmd, .byte_in(in_data_byte), .rd_idx(out_word_index),
    .cv_word(out_digest_word), .stat
  );

endmodule

FILE: tb/sv/tb_sm3_hash_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Feeds byte-stream messages through the engine and checks each digest word
// against an in-bench SM3 predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine import sm3_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sm3_hash_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       eom;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  msg_word_t   pending_words[$];
  digest_out_t expected_digest[$];

  // Predictor state: chaining value, current block bytes, byte count
  logic [31:0] hash_cv[8];
  logic [7:0]  blk_bytes[64];
  logic [60:0] byte_count;

  int  errors = 0;
  int  acc_cnt = 0;

  // Acceptance flag from the last rising edge, used by the driver
  bit  in_ready_seen;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  // One SM3 compression of blk_bytes into hash_cv
  task automatic run_compression();
    logic [31:0] w[68];
    logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, tt1, tt2, ff, gg, tj, x;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 68; i++) begin
      x = w[i-16] ^ w[i-9] ^ rol(w[i-3], 15);
      x = x ^ rol(x, 15) ^ rol(x, 23);
      w[i] = x ^ rol(w[i-13], 7) ^ w[i-6];
    end
    {a, b, c, d, e, f, g, h} = {hash_cv[0], hash_cv[1], hash_cv[2], hash_cv[3],
                                hash_cv[4], hash_cv[5], hash_cv[6], hash_cv[7]};
    for (int j = 0; j < 64; j++) begin
      if (j < 16) begin
        tj = T_LOW;
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        tj = T_HIGH;
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      ss1 = rol(rol(a, 12) + e + rol(tj, j), 7);
      ss2 = ss1 ^ rol(a, 12);
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e;
      e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    hash_cv[0] ^= a; hash_cv[1] ^= b; hash_cv[2] ^= c; hash_cv[3] ^= d;
    hash_cv[4] ^= e; hash_cv[5] ^= f; hash_cv[6] ^= g; hash_cv[7] ^= h;
  endtask

  // Advance the predictor by one accepted word; queue digest words on end mark
  task automatic predict_digest(msg_word_t mw);
    int pos;
    logic [63:0] bits;
    if (mw.has_byte) begin
      pos = byte_count[5:0];
      blk_bytes[pos] = mw.data_byte;
      byte_count = byte_count + 61'd1;
      if (pos == 63) run_compression();
    end
    if (!mw.eom) return;
    pos = byte_count[5:0];
    blk_bytes[pos] = PAD_BYTE;
    for (int i = pos + 1; i < 64; i++) blk_bytes[i] = 8'h00;
    if (pos >= 56) begin
      run_compression();
      for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    end
    bits = {byte_count, 3'b000};
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bits[63-8*i -: 8];
    run_compression();
    for (int i = 0; i < 8; i++)
      expected_digest.push_back('{hash_cv[i], 3'(i), i == 7});
    for (int i = 0; i < 8; i++) hash_cv[i] = IV[i];
    byte_count = '0;
  endtask

  // No idling while the accepted word count sits in the quiet window
  function automatic bit idle_now();
    return !(acc_cnt >= 100 && acc_cnt < 170) && ($urandom_range(99) < 34);
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hold the payload until accepted; idle at random between words
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_words.size() > 0 && !idle_now()) begin
        msg_word_t mw;
        mw = pending_words.pop_front();
        in_data_byte      <= mw.data_byte;
        in_has_byte       <= mw.has_byte;
        in_end_of_message <= mw.eom;
        in_valid          <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !idle_now();
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        acc_cnt++;
        predict_digest('{in_data_byte, in_has_byte, in_end_of_message});
      end
      if (out_valid && out_ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time,
                   out_digest_word, out_word_index);
          errors++;
        end else begin
          digest_out_t exp_w;
          exp_w = expected_digest.pop_front();
          if (exp_w.digest_word !== out_digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_w.digest_word, out_digest_word);
            errors++;
          end
          if (exp_w.word_index !== out_word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_w.word_index, out_word_index);
            errors++;
          end
          if (exp_w.last_word !== out_last_word) begin
            $display("%0t: last_word expected %0d actual %0d", $time,
                     exp_w.last_word, out_last_word);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_message(int len, bit no_byte_end, int noise_pct);
    for (int i = 0; i < len; i++) begin
      while ($urandom_range(99) < noise_pct)
        pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
      if (!no_byte_end && i == len - 1)
        pending_words.push_back('{8'($urandom), 1'b1, 1'b1});
      else
        pending_words.push_back('{8'($urandom), 1'b1, 1'b0});
    end
    if (no_byte_end || len == 0)
      pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data_byte = 0;
    in_has_byte = 0;
    in_end_of_message = 0;
    out_ready = 0;
    in_ready_seen = 0;
    for (int i = 0; i < 8; i++) hash_cv[i] = IV[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    byte_count = '0;

    // Directed: empty message, extreme bytes, ignored word, "abc"
    pending_words.push_back('{8'hFF, 1'b0, 1'b1});
    pending_words.push_back('{8'h00, 1'b1, 1'b0});
    pending_words.push_back('{8'hAA, 1'b0, 1'b0});
    pending_words.push_back('{8'hFF, 1'b1, 1'b1});
    pending_words.push_back('{8'h61, 1'b1, 1'b0});
    pending_words.push_back('{8'h62, 1'b1, 1'b0});
    pending_words.push_back('{8'h63, 1'b1, 1'b1});
    pending_words.push_back('{8'h55, 1'b1, 1'b0});
    pending_words.push_back('{8'h00, 1'b0, 1'b1});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Padding overflow, full block then bare end mark, end mark on 64th byte
    add_message(56, 1'b0, 0);
    add_message(64, 1'b1, 0);
    add_message(64, 1'b0, 0);
    while (pending_words.size() < 230) begin
      int len;
      len = ($urandom_range(3) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      if (len > 230 - pending_words.size()) len = 230 - pending_words.size();
      add_message(len, 1'($urandom_range(1)), 10);
    end

    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_digest.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
